### rtl/ofsr_pkg.sv
// shared types, codes and constants of the oled frame store refresh unit
package ofsr_pkg;

  // default geometry
  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  // command bytes that open each page
  localparam int HEAD_BYTES = 3;

  // command codes of an input item
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_DRAW    = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_REFRESH = 3'd3;
  localparam logic [2:0] CMD_ON      = 3'd4;
  localparam logic [2:0] CMD_OFF     = 3'd5;

  // controller command bytes
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD   = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
  localparam logic [7:0] PUMP_CMD      = 8'h8D;
  localparam logic [7:0] PUMP_ON       = 8'h14;
  localparam logic [7:0] PUMP_OFF      = 8'h10;
  localparam logic [7:0] DISP_ON       = 8'hAF;
  localparam logic [7:0] DISP_OFF      = 8'hAE;
  localparam logic [7:0] MASK_TOP      = 8'h80;

  // kind of the running sequence
  typedef enum logic [1:0] {
    KIND_REFRESH = 2'd0,
    KIND_ON      = 2'd1,
    KIND_OFF     = 2'd2
  } kind_t;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR   = 2'd0,
    ST_IDLE    = 2'd1,
    ST_DRAW_WR = 2'd2,
    ST_LOAD    = 2'd3
  } state_t;

  // one input item
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] col;
    logic [7:0] row;
    logic       pixel_on;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic serial_bit;
    logic is_data;
    logic byte_end;
    logic sequence_end;
  } out_item_t;

  // byte of the display on/off sequence
  function automatic logic [7:0] onoff_byte(input logic is_on, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = PUMP_CMD;
      2'd1:    b = is_on ? PUMP_ON : PUMP_OFF;
      2'd2:    b = is_on ? DISP_ON : DISP_OFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/ofsr_frame_store.sv
// page frame store: one write port, one registered read port
module ofsr_frame_store #(
  parameter int DEPTH  = ofsr_pkg::COLUMNS_DEF * ofsr_pkg::PAGES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/oled_framebuffer_serial_refresh_unit.sv
// top level: page frame store with bit-serial refresh and display on/off sequencer
//
// Holds PAGES x COLUMNS bytes of pixels and streams them one bit per tick item,
// MSB first, with the data/command flag. A tick in the middle of a byte is shifted
// out directly; the tick that opens a byte passes through the load state, since
// the byte comes from the frame store's registered read port. A draw that hits the
// screen reads the byte, then writes the modified byte through the same memory in
// the draw-write state; an off-screen draw and refresh/on/off requests stay idle.
// A clear sweeps the store one byte per cycle and starts a refresh unless a sequence
// is running, and after reset the same clearing pass runs with item_ready low.
// A result waiting in the output register stalls only ticks that would produce
// another result.
module oled_framebuffer_serial_refresh_unit #(
  parameter int COLUMNS = ofsr_pkg::COLUMNS_DEF,
  parameter int PAGES   = ofsr_pkg::PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ofsr_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output ofsr_pkg::out_item_t result
);

  localparam int DEPTH  = COLUMNS * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BYTE_W = $clog2(COLUMNS + ofsr_pkg::HEAD_BYTES);

  ofsr_pkg::state_t state, state_next;
  ofsr_pkg::kind_t  kind;
  logic              busy;
  logic [PAGE_W-1:0] page_cnt;
  logic [BYTE_W-1:0] byte_cnt;
  logic [2:0]        bit_cnt;
  logic [7:0]        shift_byte;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] draw_addr;
  logic [7:0]        draw_mask;
  logic              draw_on;

  logic              accept;
  logic              is_tick;
  logic              out_free;
  logic              pix_ok;
  logic [PAGE_W-1:0] pix_page;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic [ADDR_W-1:0] tick_addr;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [7:0]        st_wdata;
  logic [ADDR_W-1:0] st_raddr;
  logic [7:0]        st_rdata;
  logic              starts;
  logic              emit_direct;
  logic              emit_load;
  logic              emit;
  logic [7:0]        load_byte;
  logic [7:0]        cur_byte;
  logic              tx_data;
  logic              bend;
  logic              last_byte;
  logic              send;
  logic              page_done;

  // handshake decode
  assign accept   = item_valid && item_ready;
  assign is_tick  = (item.cmd == ofsr_pkg::CMD_TICK);
  assign out_free = !result_valid || result_ready;
  assign starts   = (item.cmd == ofsr_pkg::CMD_CLEAR) || (item.cmd == ofsr_pkg::CMD_REFRESH)
                 || (item.cmd == ofsr_pkg::CMD_ON) || (item.cmd == ofsr_pkg::CMD_OFF);

  // pixel address and mask
  assign pix_ok   = ({1'b0, item.col} < 9'(COLUMNS)) && ({1'b0, item.row} < 9'(8 * PAGES));
  assign pix_page = PAGE_W'(PAGES - 1) - item.row[3 +: PAGE_W];
  assign pix_addr = ADDR_W'(32'(pix_page) * COLUMNS) + ADDR_W'(item.col);
  assign pix_mask = ofsr_pkg::MASK_TOP >> item.row[2:0];

  // data byte address of the running refresh
  assign tick_addr = ADDR_W'(32'(page_cnt) * COLUMNS + 32'(byte_cnt) - ofsr_pkg::HEAD_BYTES);

  // frame store
  ofsr_frame_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ofsr_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ofsr_pkg::ST_IDLE;
        end
      end
      ofsr_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.cmd)
            ofsr_pkg::CMD_DRAW: begin
              if (pix_ok) state_next = ofsr_pkg::ST_DRAW_WR;
            end
            ofsr_pkg::CMD_CLEAR: state_next = ofsr_pkg::ST_CLEAR;
            ofsr_pkg::CMD_TICK: begin
              if (busy && (bit_cnt == 3'd0)) state_next = ofsr_pkg::ST_LOAD;
            end
            default: state_next = ofsr_pkg::ST_IDLE;
          endcase
        end
      end
      ofsr_pkg::ST_DRAW_WR: state_next = ofsr_pkg::ST_IDLE;
      ofsr_pkg::ST_LOAD:    state_next = ofsr_pkg::ST_IDLE;
      default:              state_next = ofsr_pkg::ST_IDLE;
    endcase
  end

  // state outputs: ready and store ports
  always_comb begin
    item_ready = 1'b0;
    st_we      = 1'b0;
    st_waddr   = clr_addr;
    st_wdata   = 8'h00;
    st_raddr   = tick_addr;
    case (state)
      ofsr_pkg::ST_CLEAR: begin
        st_we = 1'b1;
      end
      ofsr_pkg::ST_IDLE: begin
        item_ready = !(is_tick && busy) || out_free;
        if (item.cmd == ofsr_pkg::CMD_DRAW) st_raddr = pix_addr;
      end
      ofsr_pkg::ST_DRAW_WR: begin
        st_we    = 1'b1;
        st_waddr = draw_addr;
        st_wdata = draw_on ? (st_rdata | draw_mask) : (st_rdata & ~draw_mask);
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  // byte that opens a new byte slot
  always_comb begin
    load_byte = 8'h00;
    case (kind)
      ofsr_pkg::KIND_REFRESH: begin
        if (byte_cnt == BYTE_W'(0))      load_byte = ofsr_pkg::PAGE_CMD_BASE + 8'(page_cnt);
        else if (byte_cnt == BYTE_W'(1)) load_byte = ofsr_pkg::COL_LOW_CMD;
        else if (byte_cnt == BYTE_W'(2)) load_byte = ofsr_pkg::COL_HIGH_CMD;
        else                             load_byte = st_rdata;
      end
      ofsr_pkg::KIND_ON: begin
        if (byte_cnt < BYTE_W'(3)) load_byte = ofsr_pkg::onoff_byte(1'b1, byte_cnt[1:0]);
      end
      ofsr_pkg::KIND_OFF: begin
        if (byte_cnt < BYTE_W'(3)) load_byte = ofsr_pkg::onoff_byte(1'b0, byte_cnt[1:0]);
      end
      default: load_byte = 8'h00;
    endcase
  end

  // serial bit and flags of the current tick
  assign emit_direct = accept && is_tick && busy && (bit_cnt != 3'd0);
  assign emit_load   = (state == ofsr_pkg::ST_LOAD);
  assign emit        = emit_direct || emit_load;
  assign cur_byte    = emit_load ? load_byte : shift_byte;
  assign tx_data     = (kind == ofsr_pkg::KIND_REFRESH)
                    && (byte_cnt >= BYTE_W'(ofsr_pkg::HEAD_BYTES));
  assign bend        = (bit_cnt == 3'd7);
  assign page_done   = byte_cnt >= BYTE_W'(ofsr_pkg::HEAD_BYTES + COLUMNS - 1);
  assign last_byte   = (kind == ofsr_pkg::KIND_REFRESH)
                    ? ((page_cnt >= PAGE_W'(PAGES - 1)) && page_done)
                    : (byte_cnt >= BYTE_W'(2));
  assign send        = bend && last_byte;

  // state and sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ofsr_pkg::ST_CLEAR;
      clr_addr     <= '0;
      busy         <= 1'b0;
      kind         <= ofsr_pkg::KIND_REFRESH;
      page_cnt     <= '0;
      byte_cnt     <= '0;
      bit_cnt      <= 3'd0;
      shift_byte   <= 8'h00;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      // clearing sweep address
      if (state == ofsr_pkg::ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      else                             clr_addr <= '0;

      // output register: filled by a shifted bit, emptied by the receiver
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end

      // one bit shifted out
      if (emit) begin
        shift_byte <= {cur_byte[6:0], 1'b0};
        if (!bend) begin
          bit_cnt <= bit_cnt + 3'd1;
        end else if (send) begin
          busy     <= 1'b0;
          page_cnt <= '0;
          byte_cnt <= '0;
          bit_cnt  <= 3'd0;
        end else begin
          bit_cnt <= 3'd0;
          if ((kind == ofsr_pkg::KIND_REFRESH) && page_done) begin
            byte_cnt <= '0;
            page_cnt <= page_cnt + PAGE_W'(1);
          end else begin
            byte_cnt <= byte_cnt + BYTE_W'(1);
          end
        end
      end

      // sequence start, ignored while busy
      if (accept && starts && !busy) begin
        busy     <= 1'b1;
        page_cnt <= '0;
        byte_cnt <= '0;
        bit_cnt  <= 3'd0;
        if (item.cmd == ofsr_pkg::CMD_ON)       kind <= ofsr_pkg::KIND_ON;
        else if (item.cmd == ofsr_pkg::CMD_OFF) kind <= ofsr_pkg::KIND_OFF;
        else                                    kind <= ofsr_pkg::KIND_REFRESH;
      end
    end
  end

  // result payload and draw capture
  always_ff @(posedge clk) begin
    if (emit) begin
      result.serial_bit   <= cur_byte[7];
      result.is_data      <= tx_data;
      result.byte_end     <= bend;
      result.sequence_end <= send;
    end
    if (accept && (item.cmd == ofsr_pkg::CMD_DRAW)) begin
      draw_addr <= pix_addr;
      draw_mask <= pix_mask;
      draw_on   <= item.pixel_on;
    end
  end

endmodule

### rtl/ofsr_checker.sv
// port-level checks of the refresh unit, bound to the top level
module ofsr_checker #(
  parameter int COLUMNS = ofsr_pkg::COLUMNS_DEF,
  parameter int PAGES   = ofsr_pkg::PAGES_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input ofsr_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_ready,
  input ofsr_pkg::out_item_t result
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // reset starts the clearing pass
  assert property (@(posedge clk) rst |=> !item_ready)
    else $error("item taken during clearing pass");

  // an on-screen draw occupies the next cycle with its write
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item.cmd == ofsr_pkg::CMD_DRAW)
    && ({1'b0, item.col} < 9'(COLUMNS)) && ({1'b0, item.row} < 9'(8 * PAGES))
    |=> !item_ready)
    else $error("item taken during draw write");

  // only ticks make results
  assert property (@(posedge clk) disable iff (rst)
    !result_valid && item_valid && item_ready && (item.cmd != ofsr_pkg::CMD_TICK)
    |=> !result_valid)
    else $error("result without tick");

  // sequence end falls on a byte end
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sequence_end |-> result.byte_end)
    else $error("sequence end inside a byte");

endmodule

bind oled_framebuffer_serial_refresh_unit ofsr_checker #(
  .COLUMNS (COLUMNS),
  .PAGES   (PAGES)
) u_ofsr_checker (.*);

### tb/sv/tb.sv
// testbench for the oled frame store refresh unit: random draw, request and tick items
`timescale 1ns / 100ps

module tb;
  import ofsr_pkg::*;

  localparam int LIMIT        = 200_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MODE_SPAN    = 375;
  localparam int DRAIN_CYCLES = 20;
  localparam int LAST_DATA    = HEAD_BYTES + COLUMNS_DEF - 1;

  // predicted frame store and serial sequencer, checks every shifted bit
  class bit_stream_board;
    logic [7:0]  pixels [COLUMNS_DEF*PAGES_DEF];
    bit          busy;
    kind_t       kind;
    int unsigned page;
    int unsigned byte_idx;
    int unsigned bit_idx;
    logic [7:0]  shifting;
    out_item_t   bits_due[$];
    int unsigned mismatches;
    int unsigned refresh_starts;

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      busy = 1'b0;
      kind = KIND_REFRESH;
      page = 0;
      byte_idx = 0;
      bit_idx = 0;
      shifting = 8'h00;
      mismatches = 0;
      refresh_starts = 0;
    endfunction

    // requests are dropped while a sequence runs
    function void start_seq(kind_t k);
      if (busy) return;
      busy = 1'b1;
      kind = k;
      page = 0;
      byte_idx = 0;
      bit_idx = 0;
      if (k == KIND_REFRESH) refresh_starts++;
    endfunction

    // byte at the current sequence position
    function logic [7:0] byte_to_send();
      if (kind == KIND_REFRESH) begin
        case (byte_idx)
          0: return PAGE_CMD_BASE + 8'(page);
          1: return COL_LOW_CMD;
          2: return COL_HIGH_CMD;
          default: return pixels[page*COLUMNS_DEF + byte_idx - HEAD_BYTES];
        endcase
      end
      case (byte_idx)
        0: return PUMP_CMD;
        1: return (kind == KIND_ON) ? PUMP_ON : PUMP_OFF;
        default: return (kind == KIND_ON) ? DISP_ON : DISP_OFF;
      endcase
    endfunction

    // note one accepted item
    function void apply_item(in_item_t it);
      int unsigned pg;
      int unsigned idx;
      logic [7:0]  mask;
      bit          last_byte;
      out_item_t   e;
      case (it.cmd)
        CMD_DRAW: begin
          if (it.col < COLUMNS_DEF && it.row < 8*PAGES_DEF) begin
            pg = PAGES_DEF - 1 - it.row / 8;
            mask = MASK_TOP >> (it.row % 8);
            idx = pg*COLUMNS_DEF + it.col;
            pixels[idx] = it.pixel_on ? (pixels[idx] | mask) : (pixels[idx] & ~mask);
          end
        end
        CMD_CLEAR: begin
          foreach (pixels[i]) pixels[i] = 8'h00;
          start_seq(KIND_REFRESH);
        end
        CMD_REFRESH: start_seq(KIND_REFRESH);
        CMD_ON:      start_seq(KIND_ON);
        CMD_OFF:     start_seq(KIND_OFF);
        CMD_TICK: begin
          if (busy) begin
            if (bit_idx == 0) shifting = byte_to_send();
            e.serial_bit = shifting[7 - bit_idx];
            e.is_data = (kind == KIND_REFRESH) && (byte_idx >= HEAD_BYTES);
            e.byte_end = (bit_idx == 7);
            if (kind == KIND_REFRESH)
              last_byte = (page == PAGES_DEF - 1) && (byte_idx == LAST_DATA);
            else
              last_byte = (byte_idx == 2);
            e.sequence_end = e.byte_end && last_byte;
            bits_due.push_back(e);
            // advance bit, byte and page position
            if (!e.byte_end) begin
              bit_idx++;
            end else if (e.sequence_end) begin
              busy = 1'b0;
              page = 0;
              byte_idx = 0;
              bit_idx = 0;
            end else begin
              bit_idx = 0;
              if (kind == KIND_REFRESH && byte_idx == LAST_DATA) begin
                byte_idx = 0;
                page++;
              end else begin
                byte_idx++;
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    // compare one result with the oldest predicted bit
    function void check_bit(out_item_t got);
      out_item_t e;
      if (bits_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual sd=%b dc=%b be=%b se=%b",
                 $time, got.serial_bit, got.is_data, got.byte_end, got.sequence_end);
        return;
      end
      e = bits_due.pop_front();
      if (got.serial_bit !== e.serial_bit || got.is_data !== e.is_data ||
          got.byte_end !== e.byte_end || got.sequence_end !== e.sequence_end) begin
        mismatches++;
        $display({"%0t: result mismatch, expected sd=%b dc=%b be=%b se=%b,",
                  " actual sd=%b dc=%b be=%b se=%b"},
                 $time, e.serial_bit, e.is_data, e.byte_end, e.sequence_end,
                 got.serial_bit, got.is_data, got.byte_end, got.sequence_end);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  in_item_t    item;
  logic        result_valid;
  logic        result_ready;
  out_item_t   result;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles = 0;
  bit_stream_board board;

  oled_framebuffer_serial_refresh_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watch both handshakes; a result seen at an edge predates the item taken there
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) board.check_bit(result);
      if (item_valid && item_ready) board.apply_item(item);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [2:0] c, logic [7:0] x, logic [7:0] y,
                                         logic on);
    in_item_t it;
    it.cmd = c;
    it.col = x;
    it.row = y;
    it.pixel_on = on;
    return it;
  endfunction

  // mostly on-screen points, some off-screen
  function automatic in_item_t random_draw();
    logic [7:0] x;
    logic [7:0] y;
    x = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLUMNS_DEF - 1));
    y = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8*PAGES_DEF - 1));
    return make_item(CMD_DRAW, x, y, 1'($urandom));
  endfunction

  function automatic in_item_t random_fields(logic [2:0] c);
    return make_item(c, 8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  // one item through the input handshake, with random sender gaps
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(random_fields(CMD_TICK));
  endtask

  initial begin
    in_item_t    it;
    int unsigned n;
    int unsigned pick;
    board = new();
    item_valid = 1'b0;
    item = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corner pixels, off-screen points, unused codes, idle tick
    send_item(make_item(CMD_DRAW, 8'd0, 8'd0, 1'b1));
    send_item(make_item(CMD_DRAW, 8'd127, 8'd63, 1'b1));
    send_item(make_item(CMD_DRAW, 8'd128, 8'd5, 1'b1));
    send_item(make_item(CMD_DRAW, 8'd5, 8'd64, 1'b1));
    send_item(make_item(CMD_DRAW, 8'd255, 8'd255, 1'b1));
    send_item(make_item(CMD_DRAW, 8'd127, 8'd0, 1'b1));
    send_item(make_item(CMD_DRAW, 8'd127, 8'd0, 1'b0));
    send_item(make_item(CMD_DRAW, 8'd0, 8'd7, 1'b1));
    send_item(random_fields(3'd6));
    send_item(random_fields(3'd7));
    send_item(random_fields(CMD_TICK));

    // display on, with requests, a draw and a clear landing while busy
    send_item(random_fields(CMD_ON));
    send_item(random_fields(CMD_REFRESH));
    send_item(random_fields(CMD_OFF));
    send_item(make_item(CMD_DRAW, 8'd0, 8'd56, 1'b1));
    send_ticks(8);
    send_item(random_fields(CMD_CLEAR));
    send_ticks(16);

    // display off
    send_item(random_fields(CMD_OFF));
    send_ticks(24);

    // random traffic; a refresh starts early and runs through the rest of it
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ((n / MODE_SPAN) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      pick = $urandom_range(0, 999);
      if (board.busy) begin
        if (pick < 850) it = random_fields(CMD_TICK);
        else if (pick < 970) it = random_draw();
        else if (pick < 972) it = random_fields(CMD_CLEAR);
        else it = random_fields(3'($urandom_range(CMD_REFRESH, 7)));
      end else begin
        if (board.refresh_starts < 2 &&
            (pick < 60 || n >= 400 * (board.refresh_starts + 1)))
          it = random_fields(board.refresh_starts == 0 ? CMD_REFRESH : CMD_CLEAR);
        else if (pick < 450) it = random_fields(pick < 250 ? CMD_ON : CMD_OFF);
        else if (pick < 800) it = random_draw();
        else if (pick < 950) it = random_fields(CMD_TICK);
        else it = random_fields(3'($urandom_range(6, 7)));
      end
      send_item(it);
      n++;
    end

    // drain outstanding results
    item_valid <= 1'b0;
    while (board.bits_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### oled_framebuffer_serial_refresh_unit.f
rtl/ofsr_pkg.sv
rtl/ofsr_frame_store.sv
rtl/oled_framebuffer_serial_refresh_unit.sv
rtl/ofsr_checker.sv
tb/sv/tb.sv
